>>> sv/als_pkg.sv
// Package with the shared types, codes and constants of the alarm light sequencer.
package als_pkg;

    // Width of the slow cycle counter.
    localparam int CYCLE_BITS = 16;

    // Configuration port geometry.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int CFG_BITS  = 8;

    // Operating modes.
    localparam logic [1:0] MODE_ALARM     = 2'd0;
    localparam logic [1:0] MODE_INTRUSION = 2'd1;
    localparam logic [1:0] MODE_SILENCE   = 2'd2;
    localparam logic [1:0] MODE_OTHER     = 2'd3;

    // Light colours.
    localparam logic [2:0] COL_OFF = 3'd0;
    localparam logic [2:0] COL_WR  = 3'd1;
    localparam logic [2:0] COL_W   = 3'd2;
    localparam logic [2:0] COL_G   = 3'd3;
    localparam logic [2:0] COL_B   = 3'd4;
    localparam logic [2:0] COL_R   = 3'd5;

    // Light message destinations.
    localparam logic [1:0] DEST_NONE = 2'd0;
    localparam logic [1:0] DEST_ONE  = 2'd1;
    localparam logic [1:0] DEST_BOTH = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_INTRUSION_ALERT = 3'd0;
    localparam logic [2:0] REG_INTRUSION_WHITE = 3'd1;
    localparam logic [2:0] REG_SILENCE_WHITE   = 3'd2;
    localparam logic [2:0] REG_SILENCE_TOGGLE  = 3'd3;
    localparam logic [2:0] REG_MEASURE_PERIOD  = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] RST_INTRUSION_ALERT = 8'd1;
    localparam logic [CFG_BITS-1:0] RST_INTRUSION_WHITE = 8'd2;
    localparam logic [CFG_BITS-1:0] RST_SILENCE_WHITE   = 8'd1;
    localparam logic [CFG_BITS-1:0] RST_SILENCE_TOGGLE  = 8'd3;
    localparam logic [CFG_BITS-1:0] RST_MEASURE_PERIOD  = 8'd8;

    // One tick as it arrives.
    typedef struct packed {
        logic [1:0]            mode;
        logic [1:0]            next_mode;
        logic [CYCLE_BITS-1:0] cycle_count;
        logic                  dark;
        logic                  light_on_request;
        logic                  light_off_request;
        logic                  door_motion;
        logic                  veranda_motion;
    } in_item_t;

    // One result per tick.
    typedef struct packed {
        logic [2:0] colour;
        logic       light_active;
        logic [1:0] light_msg_dest;
        logic       long_range_pir_on;
        logic       measure_due;
    } out_item_t;

endpackage

>>> sv/alarm_light_sequencer_unit.sv
// Top level of the alarm light sequencer: input register, tick logic, result register and configuration port.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------
//  in       | in        | in_valid / in_stall | in_data  (als_pkg::in_item_t)
//  out      | out       | out_valid/out_stall | out_data (als_pkg::out_item_t)
//  config   | in        | APB psel/penable    | paddr, pwdata, prdata
//
// One transaction is accepted per clock cycle unless in_stall is high; it waits in the input
// register until the result register is free, and its result is then registered there.
// The tick logic sits between the input register and the result register.
// Reset clears the light state, the marks, the valid flags and the configuration registers to defaults.
// A stall on the output holds the result; the input register keeps taking a transaction
// as long as it is empty or the result register is free or is being emptied in the same cycle.
module alarm_light_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  als_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output als_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [als_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [als_pkg::DATA_BITS-1:0]     pwdata,
    output logic [als_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);

    // Configuration registers.
    logic [als_pkg::CFG_BITS-1:0] intrusion_alert_reg;
    logic [als_pkg::CFG_BITS-1:0] intrusion_white_reg;
    logic [als_pkg::CFG_BITS-1:0] silence_white_reg;
    logic [als_pkg::CFG_BITS-1:0] silence_toggle_reg;
    logic [als_pkg::CFG_BITS-1:0] measure_period_reg;
    logic [2:0]                   cfg_index;
    logic                         cfg_write;

    // Pipeline registers.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    als_pkg::in_item_t  s1_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    als_pkg::out_item_t out_data_reg;
    als_pkg::out_item_t out_data_next;
    logic               s1_advance;
    logic               s1_fire;
    logic               in_accept;

    // Sequencer state.
    logic [2:0]                     colour_reg;
    logic [2:0]                     colour_next;
    logic [als_pkg::CYCLE_BITS-1:0] light_mark_reg;
    logic [als_pkg::CYCLE_BITS-1:0] light_mark_next;
    logic [als_pkg::CYCLE_BITS-1:0] measure_mark_reg;
    logic [als_pkg::CYCLE_BITS-1:0] measure_mark_next;

    // Tick logic intermediates.
    logic [als_pkg::CYCLE_BITS-1:0] now;
    logic [als_pkg::CYCLE_BITS-1:0] light_mark;
    logic [als_pkg::CYCLE_BITS-1:0] light_elapsed;
    logic [als_pkg::CYCLE_BITS-1:0] measure_mark;
    logic [als_pkg::CYCLE_BITS-1:0] measure_elapsed;
    logic [1:0]                     dest;
    logic                           motion;
    logic                           due;

    // Configuration port: always ready, write on the access cycle.
    assign pready    = 1'b1;
    assign cfg_index = paddr[als_pkg::ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intrusion_alert_reg <= als_pkg::RST_INTRUSION_ALERT;
            intrusion_white_reg <= als_pkg::RST_INTRUSION_WHITE;
            silence_white_reg   <= als_pkg::RST_SILENCE_WHITE;
            silence_toggle_reg  <= als_pkg::RST_SILENCE_TOGGLE;
            measure_period_reg  <= als_pkg::RST_MEASURE_PERIOD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                als_pkg::REG_INTRUSION_ALERT: intrusion_alert_reg <= pwdata[als_pkg::CFG_BITS-1:0];
                als_pkg::REG_INTRUSION_WHITE: intrusion_white_reg <= pwdata[als_pkg::CFG_BITS-1:0];
                als_pkg::REG_SILENCE_WHITE:   silence_white_reg   <= pwdata[als_pkg::CFG_BITS-1:0];
                als_pkg::REG_SILENCE_TOGGLE:  silence_toggle_reg  <= pwdata[als_pkg::CFG_BITS-1:0];
                als_pkg::REG_MEASURE_PERIOD:  measure_period_reg  <= pwdata[als_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            als_pkg::REG_INTRUSION_ALERT: prdata[als_pkg::CFG_BITS-1:0] = intrusion_alert_reg;
            als_pkg::REG_INTRUSION_WHITE: prdata[als_pkg::CFG_BITS-1:0] = intrusion_white_reg;
            als_pkg::REG_SILENCE_WHITE:   prdata[als_pkg::CFG_BITS-1:0] = silence_white_reg;
            als_pkg::REG_SILENCE_TOGGLE:  prdata[als_pkg::CFG_BITS-1:0] = silence_toggle_reg;
            als_pkg::REG_MEASURE_PERIOD:  prdata[als_pkg::CFG_BITS-1:0] = measure_period_reg;
            default: prdata = '0;
        endcase
    end

    // Flow control: the input register moves on when the result register is empty or not stalled.
    assign s1_advance = !out_valid_reg || !out_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // Light sequencing and measurement timing for the tick in the input register.
    always_comb
    begin
        now         = s1_data_reg.cycle_count;
        light_mark  = (now < light_mark_reg) ? now : light_mark_reg;
        light_elapsed = now - light_mark;
        colour_next = colour_reg;
        light_mark_next = light_mark;
        dest        = als_pkg::DEST_NONE;
        motion      = s1_data_reg.door_motion || s1_data_reg.veranda_motion;

        case (s1_data_reg.mode)
            als_pkg::MODE_ALARM:
            begin
                if (light_mark != now)
                begin
                    if (s1_data_reg.dark)
                    begin
                        colour_next = (colour_reg != als_pkg::COL_WR) ? als_pkg::COL_WR
                                                                     : als_pkg::COL_W;
                    end
                    else
                    begin
                        colour_next = (colour_reg != als_pkg::COL_R) ? als_pkg::COL_R
                                                                    : als_pkg::COL_OFF;
                    end
                    light_mark_next = now;
                end
            end
            als_pkg::MODE_INTRUSION:
            begin
                if (!(colour_reg inside {als_pkg::COL_WR, als_pkg::COL_W}))
                begin
                    if (s1_data_reg.dark && (motion || s1_data_reg.light_on_request))
                    begin
                        colour_next     = als_pkg::COL_WR;
                        light_mark_next = now;
                        if (motion)
                        begin
                            dest = als_pkg::DEST_BOTH;
                        end
                    end
                end
                else if (colour_reg == als_pkg::COL_WR)
                begin
                    if (light_elapsed > {{(als_pkg::CYCLE_BITS-als_pkg::CFG_BITS){1'b0}},
                                         intrusion_alert_reg})
                    begin
                        colour_next     = als_pkg::COL_W;
                        light_mark_next = now;
                    end
                end
                else
                begin
                    if (light_elapsed > {{(als_pkg::CYCLE_BITS-als_pkg::CFG_BITS){1'b0}},
                                         intrusion_white_reg})
                    begin
                        colour_next     = als_pkg::COL_OFF;
                        light_mark_next = now;
                    end
                end
            end
            als_pkg::MODE_SILENCE:
            begin
                if (colour_reg != als_pkg::COL_W)
                begin
                    if (s1_data_reg.dark &&
                        (s1_data_reg.door_motion || s1_data_reg.light_on_request))
                    begin
                        colour_next     = als_pkg::COL_W;
                        light_mark_next = now;
                        if (s1_data_reg.door_motion)
                        begin
                            dest = als_pkg::DEST_ONE;
                        end
                    end
                    else if (light_elapsed >
                             {{(als_pkg::CYCLE_BITS-als_pkg::CFG_BITS){1'b0}},
                              silence_toggle_reg})
                    begin
                        colour_next     = als_pkg::COL_OFF;
                        light_mark_next = now;
                    end
                    else if (colour_reg == als_pkg::COL_B)
                    begin
                        colour_next = als_pkg::COL_G;
                    end
                    else if (colour_reg == als_pkg::COL_G)
                    begin
                        colour_next = als_pkg::COL_B;
                    end
                end
                else
                begin
                    if (light_elapsed > {{(als_pkg::CYCLE_BITS-als_pkg::CFG_BITS){1'b0}},
                                         silence_white_reg})
                    begin
                        colour_next     = als_pkg::COL_G;
                        light_mark_next = now;
                    end
                end
            end
            default: ;
        endcase

        // A pending mode change or a disable command forces the light off.
        if ((s1_data_reg.mode != s1_data_reg.next_mode) || s1_data_reg.light_off_request)
        begin
            colour_next = als_pkg::COL_OFF;
        end

        // Measurement is due once the period has passed since the last one.
        measure_mark    = (now < measure_mark_reg) ? now : measure_mark_reg;
        measure_elapsed = now - measure_mark;
        due = measure_elapsed > {{(als_pkg::CYCLE_BITS-als_pkg::CFG_BITS){1'b0}},
                                 measure_period_reg};
        measure_mark_next = due ? now : measure_mark;

        out_data_next.colour            = colour_next;
        out_data_next.light_active      = (colour_next != als_pkg::COL_OFF);
        out_data_next.light_msg_dest    = dest;
        out_data_next.long_range_pir_on = s1_data_reg.dark;
        out_data_next.measure_due       = due;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            colour_reg       <= als_pkg::COL_OFF;
            light_mark_reg   <= '0;
            measure_mark_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                colour_reg       <= colour_next;
                light_mark_reg   <= light_mark_next;
                measure_mark_reg <= measure_mark_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/als_checker.sv
// Port checker for the alarm light sequencer and its bind to the top level.
module als_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input als_pkg::out_item_t            out_data
);

    // A stalled result transaction stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    // The activity flag agrees with the colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.light_active == (out_data.colour != als_pkg::COL_OFF))
        else $error("light_active disagrees with colour");

    // A message to both peers only comes with white plus red, or with a forced off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.light_msg_dest == als_pkg::DEST_BOTH |->
            out_data.colour == als_pkg::COL_WR || out_data.colour == als_pkg::COL_OFF)
        else $error("message to both peers with wrong colour");

    // A message to one peer only comes with white, or with a forced off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.light_msg_dest == als_pkg::DEST_ONE |->
            out_data.colour == als_pkg::COL_W || out_data.colour == als_pkg::COL_OFF)
        else $error("message to one peer with wrong colour");

    // Colour and destination codes stay within their defined sets.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.colour <= als_pkg::COL_R &&
                      out_data.light_msg_dest != 2'd3)
        else $error("undefined colour or destination code");

endmodule

bind alarm_light_sequencer_unit als_checker u_als_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/tb_alarm_light_sequencer_unit.sv
// Self-checking bench for the alarm light sequencer: directed ticks, then random ones.
module tb_alarm_light_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 7;
    localparam int PHASE_TICKS = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 60;

    // Register index with no register behind it; writes there must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // One row of the directed table: the tick and, where typed, its report.
    typedef struct packed {
        als_pkg::in_item_t  tick;
        logic               typed;
        als_pkg::out_item_t report;
    } row_t;

    localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Values straight after reset, then a count at its top.
        '{'{als_pkg::MODE_OTHER, als_pkg::MODE_OTHER, 16'h0000,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        '{'{als_pkg::MODE_OTHER, als_pkg::MODE_OTHER, 16'hFFFF,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b1, 1'b1}},
        // Backward count resyncs the measurement mark.
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h0000,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        // Alarm toggling, dark and then light.
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h0001,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_WR, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h0002,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h0003,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_R, 1'b1, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h0004,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        // Intrusion: door motion starts white+red, then white, then off.
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h0005,
            1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
          '{als_pkg::COL_WR, 1'b1, als_pkg::DEST_BOTH, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h0006,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_WR, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h0007,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h0009,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b1}},
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h000A,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        // Mode change forces the light off but keeps the message.
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_SILENCE, 16'h000B,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_BOTH, 1'b1, 1'b0}},
        // Enable and disable together: disable wins.
        '{'{als_pkg::MODE_INTRUSION, als_pkg::MODE_INTRUSION, 16'h000C,
            1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        // Silence: white, green/blue toggle, then off.
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h000D,
            1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_ONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h000F,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_G, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h0010,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_B, 1'b1, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h0011,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_G, 1'b1, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h0013,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b1}},
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h0014,
            1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        // Other mode leaves the light alone unless the next mode differs.
        '{'{als_pkg::MODE_OTHER, als_pkg::MODE_OTHER, 16'h0015,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_W, 1'b1, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        '{'{als_pkg::MODE_OTHER, als_pkg::MODE_ALARM, 16'h0016,
            1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b1, 1'b0}},
        // Silence while off with no start re-marks the cycle and stays off.
        '{'{als_pkg::MODE_SILENCE, als_pkg::MODE_SILENCE, 16'h001E,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b1}},
        // Remaining extremes are left to the predictor.
        '{'{als_pkg::MODE_ALARM, als_pkg::MODE_ALARM, 16'h8000,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b0}},
        '{'{als_pkg::MODE_OTHER, als_pkg::MODE_OTHER, 16'hFFFF,
            1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0,
          '{als_pkg::COL_OFF, 1'b0, als_pkg::DEST_NONE, 1'b0, 1'b0}}
    };

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    als_pkg::in_item_t             in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    als_pkg::out_item_t            out_data;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [als_pkg::ADDR_BITS-1:0] paddr     = '0;
    logic [als_pkg::DATA_BITS-1:0] pwdata    = '0;
    logic [als_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;

    // Predictor state and its copy of the settings.
    logic [2:0]                     lamp_colour;
    logic [als_pkg::CYCLE_BITS-1:0] lamp_mark;
    logic [als_pkg::CYCLE_BITS-1:0] measure_mark;
    logic [als_pkg::CFG_BITS-1:0]   cfg_regs [0:4];

    als_pkg::out_item_t reports_owed [$];
    int                 fails        = 0;
    int                 results_seen = 0;
    int                 stall_left   = 0;
    int                 clock_ticks  = 0;

    alarm_light_sequencer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Work out the report of one tick and advance the light and measurement state.
    function automatic als_pkg::out_item_t sequence_tick(als_pkg::in_item_t t);
        als_pkg::out_item_t             rep;
        logic [als_pkg::CYCLE_BITS-1:0] now;
        logic [als_pkg::CYCLE_BITS-1:0] span;
        logic [als_pkg::CYCLE_BITS-1:0] since_measure;
        logic                           motion;
        rep = '0;
        rep.light_msg_dest = als_pkg::DEST_NONE;
        now = t.cycle_count;
        motion = t.door_motion | t.veranda_motion;

        // A count below the light mark pulls the mark back to it.
        if (now < lamp_mark)
            lamp_mark = now;
        span = now - lamp_mark;

        case (t.mode)
            als_pkg::MODE_ALARM:
            begin
                if (lamp_mark != now)
                begin
                    if (t.dark)
                        lamp_colour = (lamp_colour != als_pkg::COL_WR) ? als_pkg::COL_WR
                                                                      : als_pkg::COL_W;
                    else
                        lamp_colour = (lamp_colour != als_pkg::COL_R) ? als_pkg::COL_R
                                                                     : als_pkg::COL_OFF;
                    lamp_mark = now;
                end
            end
            als_pkg::MODE_INTRUSION:
            begin
                if (lamp_colour != als_pkg::COL_WR && lamp_colour != als_pkg::COL_W)
                begin
                    if (t.dark && (motion || t.light_on_request))
                    begin
                        lamp_colour = als_pkg::COL_WR;
                        lamp_mark = now;
                        if (motion)
                            rep.light_msg_dest = als_pkg::DEST_BOTH;
                    end
                end
                else if (lamp_colour == als_pkg::COL_WR)
                begin
                    if (span > cfg_regs[als_pkg::REG_INTRUSION_ALERT])
                    begin
                        lamp_colour = als_pkg::COL_W;
                        lamp_mark = now;
                    end
                end
                else if (span > cfg_regs[als_pkg::REG_INTRUSION_WHITE])
                begin
                    lamp_colour = als_pkg::COL_OFF;
                    lamp_mark = now;
                end
            end
            als_pkg::MODE_SILENCE:
            begin
                if (lamp_colour != als_pkg::COL_W)
                begin
                    if (t.dark && (t.door_motion || t.light_on_request))
                    begin
                        lamp_colour = als_pkg::COL_W;
                        lamp_mark = now;
                        if (t.door_motion)
                            rep.light_msg_dest = als_pkg::DEST_ONE;
                    end
                    else if (span > cfg_regs[als_pkg::REG_SILENCE_TOGGLE])
                    begin
                        lamp_colour = als_pkg::COL_OFF;
                        lamp_mark = now;
                    end
                    else if (lamp_colour == als_pkg::COL_B)
                        lamp_colour = als_pkg::COL_G;
                    else if (lamp_colour == als_pkg::COL_G)
                        lamp_colour = als_pkg::COL_B;
                end
                else if (span > cfg_regs[als_pkg::REG_SILENCE_WHITE])
                begin
                    lamp_colour = als_pkg::COL_G;
                    lamp_mark = now;
                end
            end
            default:
            begin
            end
        endcase

        // A pending mode change or a disable command turns the light off.
        if (t.mode != t.next_mode || t.light_off_request)
            lamp_colour = als_pkg::COL_OFF;

        // Measurement timing.
        if (now < measure_mark)
            measure_mark = now;
        since_measure = now - measure_mark;
        rep.measure_due = (since_measure > cfg_regs[als_pkg::REG_MEASURE_PERIOD]);
        if (rep.measure_due)
            measure_mark = now;

        rep.colour = lamp_colour;
        rep.light_active = (lamp_colour != als_pkg::COL_OFF);
        rep.long_range_pir_on = t.dark;
        return rep;
    endfunction

    // Offer one tick after a random gap, none when quiet, and log its report once it is taken.
    task automatic offer_tick(als_pkg::in_item_t t, logic typed,
                              als_pkg::out_item_t typed_report, logic quiet);
        int                 gap;
        als_pkg::out_item_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (in_stall);
        predicted = sequence_tick(t);
        reports_owed.push_back(typed ? typed_report : predicted);
    endtask

    // Stop offering and wait until every owed report has come back.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (reports_owed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle. The caller releases the bus.
    task automatic write_reg(logic [2:0] idx, logic [als_pkg::DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= als_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx <= als_pkg::REG_MEASURE_PERIOD)
            cfg_regs[idx] = value[als_pkg::CFG_BITS-1:0];
    endtask

    // Compare one report transaction with the oldest owed report.
    task automatic check_report(als_pkg::out_item_t got);
        als_pkg::out_item_t want;
        if (reports_owed.size() == 0)
        begin
            $error("report with nothing owed: colour %0d", got.colour);
            fails++;
            return;
        end
        want = reports_owed.pop_front();
        if (got.colour !== want.colour)
        begin
            $error("colour: expected %0d, got %0d", want.colour, got.colour);
            fails++;
        end
        if (got.light_active !== want.light_active)
        begin
            $error("light_active: expected %0d, got %0d", want.light_active, got.light_active);
            fails++;
        end
        if (got.light_msg_dest !== want.light_msg_dest)
        begin
            $error("light_msg_dest: expected %0d, got %0d",
                   want.light_msg_dest, got.light_msg_dest);
            fails++;
        end
        if (got.long_range_pir_on !== want.long_range_pir_on)
        begin
            $error("long_range_pir_on: expected %0d, got %0d",
                   want.long_range_pir_on, got.long_range_pir_on);
            fails++;
        end
        if (got.measure_due !== want.measure_due)
        begin
            $error("measure_due: expected %0d, got %0d", want.measure_due, got.measure_due);
            fails++;
        end
    endtask

    // Report side: check each transaction, then draw the stall before the next one.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            check_report(out_data);
            results_seen++;
            if (results_seen == HOLD_AT)
                stall_left = HOLD_CYCLES;
            else if (results_seen % 90 < 25)
                stall_left = 0;
            else
                stall_left = $urandom_range(0, 12);
        end
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        clock_ticks++;
        if (clock_ticks > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, directed table, then random phases under changing settings.
    initial
    begin
        als_pkg::in_item_t              tick;
        logic [als_pkg::CYCLE_BITS-1:0] walk;
        logic [1:0]                     walk_mode;
        logic [als_pkg::CFG_BITS-1:0]   level;
        int                             phase;
        int                             k;
        int                             idx;
        int                             roll;

        lamp_colour = als_pkg::COL_OFF;
        lamp_mark = '0;
        measure_mark = '0;
        cfg_regs[als_pkg::REG_INTRUSION_ALERT] = als_pkg::RST_INTRUSION_ALERT;
        cfg_regs[als_pkg::REG_INTRUSION_WHITE] = als_pkg::RST_INTRUSION_WHITE;
        cfg_regs[als_pkg::REG_SILENCE_WHITE] = als_pkg::RST_SILENCE_WHITE;
        cfg_regs[als_pkg::REG_SILENCE_TOGGLE] = als_pkg::RST_SILENCE_TOGGLE;
        cfg_regs[als_pkg::REG_MEASURE_PERIOD] = als_pkg::RST_MEASURE_PERIOD;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
            offer_tick(DIRECTED_ROWS[k].tick, DIRECTED_ROWS[k].typed,
                       DIRECTED_ROWS[k].report, 1'b0);

        walk = 16'h0020;
        walk_mode = als_pkg::MODE_ALARM;
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            // New settings only once the block has gone quiet.
            wait_for_idle();
            for (idx = als_pkg::REG_INTRUSION_ALERT; idx <= als_pkg::REG_MEASURE_PERIOD; idx++)
            begin
                case (phase)
                    0: level = '0;
                    1: level = '1;
                    2: level = als_pkg::CFG_BITS'($urandom);
                    default: level = als_pkg::CFG_BITS'($urandom_range(0, 5));
                endcase
                write_reg(3'(idx), {24'($urandom), level});
            end
            write_reg(REG_UNUSED, $urandom);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;

            // Mostly slow forward counts within a held mode, with some noise.
            for (k = 0; k < PHASE_TICKS; k++)
            begin
                if ($urandom_range(0, 99) < 8)
                    walk_mode = 2'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 88)
                    walk = walk + als_pkg::CYCLE_BITS'($urandom_range(0, 3));
                else if (roll < 95)
                    walk = walk - als_pkg::CYCLE_BITS'($urandom_range(1, 40));
                else
                    walk = als_pkg::CYCLE_BITS'($urandom);
                tick.mode = walk_mode;
                tick.next_mode = ($urandom_range(0, 19) == 0) ? 2'($urandom) : walk_mode;
                tick.cycle_count = walk;
                tick.dark = ($urandom_range(0, 3) != 0);
                tick.light_on_request = ($urandom_range(0, 7) == 0);
                tick.light_off_request = ($urandom_range(0, 24) == 0);
                tick.door_motion = ($urandom_range(0, 5) == 0);
                tick.veranda_motion = ($urandom_range(0, 5) == 0);
                offer_tick(tick, 1'b0, '0, k < 15);
            end
        end

        wait_for_idle();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> alarm_light_sequencer_unit.f
sv/als_pkg.sv
sv/alarm_light_sequencer_unit.sv
sv/als_checker.sv
tb/tb_alarm_light_sequencer_unit.sv
